// ===== sv/signed_unsigned_integer_divider_core_defines.svh =====
// ---------------------------------------------------------------------------
// Divider assertion macros
// Shared concurrent assertion shorthands; expects clock and reset in scope.
// ---------------------------------------------------------------------------
`ifndef SIGNED_UNSIGNED_INTEGER_DIVIDER_CORE_DEFINES_SVH
`define SIGNED_UNSIGNED_INTEGER_DIVIDER_CORE_DEFINES_SVH

// same-cycle implication
`define SUDIV_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sudiv assertion failed");

// next-cycle implication
`define SUDIV_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sudiv assertion failed");

`endif

// ===== sv/sudiv_pkg.sv =====
// ---------------------------------------------------------------------------
// Divider package
// Shared types, command codes and defaults for the bit-slice divider.
// ---------------------------------------------------------------------------
package sudiv_pkg;

   localparam int WIDTH_DEFAULT = 32;
   localparam int FIELD_WIDTH   = 32;

   typedef enum logic [1:0] {
      CMD_UQUO = 2'd0,
      CMD_UREM = 2'd1,
      CMD_SQUO = 2'd2,
      CMD_SREM = 2'd3
   } sudiv_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FIN
   } sudiv_state_type;

   // sequencer strobes
   typedef struct packed {
      logic accept;
      logic step;
      logic finish;
   } sudiv_ctrl_type;

   // broadcast to every bit cell
   typedef struct packed {
      logic load;
      logic step;
      logic qbit;
   } sudiv_cell_ctl_type;

endpackage

// ===== sv/sudiv_cell.sv =====
// ---------------------------------------------------------------------------
// Divider bit cell
// Holds one bit of partial remainder, dividend/quotient and divisor; forms
// one bit of the trial subtract and shifts its bits to the next cell up.
// ---------------------------------------------------------------------------
module sudiv_cell (
   input  logic                        clock,
   input  sudiv_pkg::sudiv_cell_ctl_type ctl,
   input  logic                        load_n,
   input  logic                        load_d,
   input  logic                        rem_shift,
   input  logic                        nq_shift,
   input  logic                        bin,
   output logic                        bout,
   output logic                        rem_bit,
   output logic                        nq_bit
);

   logic r_ff, r_in;
   logic nq_ff, nq_in;
   logic d_ff, d_in;
   logic diff;

   assign diff = rem_shift ^ d_ff ^ bin;
   assign bout = (~rem_shift & d_ff) | (~rem_shift & bin) | (d_ff & bin);

   always_comb begin
      r_in  = r_ff;
      nq_in = nq_ff;
      d_in  = d_ff;
      if (ctl.load) begin
         r_in  = 1'b0;
         nq_in = load_n;
         d_in  = load_d;
      end else if (ctl.step) begin
         r_in  = ctl.qbit ? diff : rem_shift;
         nq_in = nq_shift;
      end
   end

   always_ff @(posedge clock) begin
      r_ff  <= r_in;
      nq_ff <= nq_in;
      d_ff  <= d_in;
   end

   assign rem_bit = r_ff;
   assign nq_bit  = nq_ff;

endmodule

// ===== sv/sudiv_ctrl.sv =====
// ---------------------------------------------------------------------------
// Divider sequencer
// Takes one beat, runs WIDTH shift/subtract steps, then hands off the result.
// ---------------------------------------------------------------------------
`include "signed_unsigned_integer_divider_core_defines.svh"

module sudiv_ctrl #(
   parameter int WIDTH = sudiv_pkg::WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  out_free,
   output logic                  busy,
   output sudiv_pkg::sudiv_ctrl_type ctrl
);

   localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   sudiv_pkg::sudiv_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          last_step;

   assign last_step = (count_ff == CW'(WIDTH - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sudiv_pkg::ST_IDLE: begin
            if (req_valid) state_in = sudiv_pkg::ST_RUN;
         end
         sudiv_pkg::ST_RUN: begin
            if (last_step) state_in = sudiv_pkg::ST_FIN;
         end
         sudiv_pkg::ST_FIN: begin
            if (out_free) state_in = sudiv_pkg::ST_IDLE;
         end
         default: state_in = sudiv_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy        = 1'b1;
      ctrl.accept = 1'b0;
      ctrl.step   = 1'b0;
      ctrl.finish = 1'b0;
      case (state_ff)
         sudiv_pkg::ST_IDLE: begin
            busy        = 1'b0;
            ctrl.accept = req_valid;
         end
         sudiv_pkg::ST_RUN: begin
            ctrl.step = 1'b1;
         end
         sudiv_pkg::ST_FIN: begin
            ctrl.finish = out_free;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.accept) begin
         count_in = '0;
      end else if (ctrl.step) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sudiv_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   `SUDIV_ASSERT_NEXT(a_accept_starts, ctrl.accept, state_ff == sudiv_pkg::ST_RUN && count_ff == '0)
   `SUDIV_ASSERT_NEXT(a_last_step_fin, ctrl.step && last_step, state_ff == sudiv_pkg::ST_FIN)
   `SUDIV_ASSERT_NOW(a_one_strobe, 1'b1, $onehot0({ctrl.accept, ctrl.step, ctrl.finish}))

endmodule

// ===== sv/signed_unsigned_integer_divider_core.sv =====
// ---------------------------------------------------------------------------
// Signed/unsigned integer divider core
// Restoring long division on a row of bit cells, one quotient bit per cycle.
// ---------------------------------------------------------------------------
// Usage:
//   req_ channel carries command, dividend and divisor; a beat is taken when
//   req_valid is high and req_stall is low. Commands: unsigned quotient,
//   unsigned remainder, signed quotient, signed remainder.
//   rsp_ channel returns one result beat per request beat.
// Timing:
//   The request is loaded into the cell row at the accepting edge, then
//   WIDTH shift/subtract steps run, then the finish state applies the sign
//   fix-up and writes the output register once it is free; rsp_valid rises
//   with that write. A new beat is not taken until the result is written,
//   as the single subtract chain across the cells is shared by every step.
//   req_stall is high from acceptance until the result is written.
// Stall: a held result waits in the output register; the finished division
//   waits in the cells until the output register frees up.
// Reset: synchronous; clears the sequencer and rsp_valid, no data flushed.
// Divide by zero gives quotient 0 and remainder equal to the dividend.
// ---------------------------------------------------------------------------
`include "signed_unsigned_integer_divider_core_defines.svh"

module signed_unsigned_integer_divider_core #(
   parameter int WIDTH = sudiv_pkg::WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_dividend,
   input  logic [31:0] req_divisor,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result
);

   localparam int FW = sudiv_pkg::FIELD_WIDTH;
   localparam int PW = (WIDTH > FW) ? WIDTH : FW;

   sudiv_pkg::sudiv_ctrl_type     ctrl;
   sudiv_pkg::sudiv_cell_ctl_type cell_ctl;
   sudiv_pkg::sudiv_cmd_type      cmd_req;

   logic [PW-1:0]    a_ext, b_ext, res_ext;
   logic [WIDTH-1:0] a_w, b_w, mag_a, mag_b;
   logic             is_signed, neg_a, neg_b;

   sudiv_pkg::sudiv_cmd_type cmd_ff, cmd_in;
   logic a_neg_ff, a_neg_in;
   logic b_neg_ff, b_neg_in;
   logic zero_ff, zero_in;

   logic [WIDTH-1:0] r_vec, nq_vec, r_sh, nq_sh;
   logic [WIDTH:0]   borrow;
   logic             qbit;
   logic [WIDTH-1:0] quo, res_w;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      result_ff, result_in;
   logic             out_free, busy;
   logic             fin_zero_uquo;

   // operand conditioning
   assign cmd_req   = sudiv_pkg::sudiv_cmd_type'(req_command);
   assign a_ext     = PW'(req_dividend);
   assign b_ext     = PW'(req_divisor);
   assign a_w       = a_ext[WIDTH-1:0];
   assign b_w       = b_ext[WIDTH-1:0];
   assign is_signed = (cmd_req == sudiv_pkg::CMD_SQUO) || (cmd_req == sudiv_pkg::CMD_SREM);
   assign neg_a     = is_signed & a_w[WIDTH-1];
   assign neg_b     = is_signed & b_w[WIDTH-1];
   assign mag_a     = neg_a ? ({WIDTH{1'b0}} - a_w) : a_w;
   assign mag_b     = neg_b ? ({WIDTH{1'b0}} - b_w) : b_w;

   assign out_free  = !rsp_valid_ff || !rsp_stall;

   sudiv_ctrl #(
      .WIDTH (WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .busy      (busy),
      .ctrl      (ctrl)
   );

   assign req_stall = busy;

   // remainder top bit set means r<<1 overflows: subtraction always fits
   assign qbit          = r_vec[WIDTH-1] | ~borrow[WIDTH];
   assign cell_ctl.load = ctrl.accept;
   assign cell_ctl.step = ctrl.step;
   assign cell_ctl.qbit = qbit;

   assign r_sh      = {r_vec[WIDTH-2:0], nq_vec[WIDTH-1]};
   assign nq_sh     = {nq_vec[WIDTH-2:0], qbit};
   assign borrow[0] = 1'b0;

   for (genvar i = 0; i < WIDTH; i++) begin : g_cell
      sudiv_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl),
         .load_n    (mag_a[i]),
         .load_d    (mag_b[i]),
         .rem_shift (r_sh[i]),
         .nq_shift  (nq_sh[i]),
         .bin       (borrow[i]),
         .bout      (borrow[i+1]),
         .rem_bit   (r_vec[i]),
         .nq_bit    (nq_vec[i])
      );
   end

   always_comb begin
      cmd_in   = cmd_ff;
      a_neg_in = a_neg_ff;
      b_neg_in = b_neg_ff;
      zero_in  = zero_ff;
      if (ctrl.accept) begin
         cmd_in   = cmd_req;
         a_neg_in = neg_a;
         b_neg_in = neg_b;
         zero_in  = (b_w == '0);
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      a_neg_ff <= a_neg_in;
      b_neg_ff <= b_neg_in;
      zero_ff  <= zero_in;
   end

   // zero divisor runs as all-ones quotient; force it to 0
   assign quo = zero_ff ? '0 : nq_vec;

   always_comb begin
      case (cmd_ff)
         sudiv_pkg::CMD_UQUO: res_w = quo;
         sudiv_pkg::CMD_UREM: res_w = r_vec;
         sudiv_pkg::CMD_SQUO: res_w = (a_neg_ff ^ b_neg_ff) ? ({WIDTH{1'b0}} - quo) : quo;
         sudiv_pkg::CMD_SREM: res_w = a_neg_ff ? ({WIDTH{1'b0}} - r_vec) : r_vec;
         default:             res_w = quo;
      endcase
   end

   assign res_ext = PW'(res_w);

   always_comb begin
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.finish) begin
         result_in    = res_ext[31:0];
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

   assign fin_zero_uquo = ctrl.finish && zero_ff && (cmd_ff == sudiv_pkg::CMD_UQUO);

   `SUDIV_ASSERT_NEXT(a_finish_valid, ctrl.finish, rsp_valid)
   `SUDIV_ASSERT_NEXT(a_zero_uquo, fin_zero_uquo, rsp_result == '0)
   `SUDIV_ASSERT_NOW(a_no_finish_blocked, ctrl.finish, !(rsp_valid && rsp_stall))

endmodule

// ===== tb/sv/tb.sv =====
// ---------------------------------------------------------------------------
// Divider core testbench
// Drives divide commands through the req_ channel and checks every result
// beat against a bit-accurate restoring-division predictor. Directed corner
// cases come first, then random operands. Both sides idle and stall at random.
// ---------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int          RANDOM_BEATS = 1400;
   localparam int          DRAIN_CYCLES = 80;

   // corner operand pairs, run under every command
   localparam logic [31:0] EDGE_DIVIDEND [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                                 32'hFFFF_FFFF, 32'hFFFF_FFF9, 32'h0000_0007};
   localparam logic [31:0] EDGE_DIVISOR  [6] = '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                                                 32'h0000_0001, 32'h0000_0002, 32'hFFFF_FFFE};

   typedef struct {
      sudiv_pkg::sudiv_cmd_type cmd;
      logic [31:0]              dividend;
      logic [31:0]              divisor;
      int                       gap;
      bit                       drain;
   } div_beat_type;

   typedef struct {
      sudiv_pkg::sudiv_cmd_type cmd;
      logic [31:0]              dividend;
      logic [31:0]              divisor;
      logic [31:0]              result;
   } div_expect_type;

   logic        clock;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command  = sudiv_pkg::CMD_UQUO;
   logic [31:0] req_dividend = '0;
   logic [31:0] req_divisor  = '0;
   logic        rsp_valid;
   logic        rsp_stall    = 1'b0;
   logic [31:0] rsp_result;

   div_beat_type   pending_beats[$];
   div_expect_type expected_results[$];
   int             beats_in     = 0;
   int             beats_out    = 0;
   int             error_count  = 0;
   int             gap_left     = -1;
   int             stall_left   = 0;
   int unsigned    cycle_count  = 0;

   signed_unsigned_integer_divider_core u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_command  (req_command),
      .req_dividend (req_dividend),
      .req_divisor  (req_divisor),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_result   (rsp_result)
   );

   // restoring long division on magnitudes, sign fix-up for signed commands
   function automatic logic [31:0] divide_result(sudiv_pkg::sudiv_cmd_type cmd, logic [31:0] a,
                                                 logic [31:0] b);
      logic        is_signed;
      logic        a_neg;
      logic        b_neg;
      logic [31:0] n;
      logic [31:0] d;
      logic [31:0] quo;
      logic [32:0] rem;
      is_signed = (cmd == sudiv_pkg::CMD_SQUO) || (cmd == sudiv_pkg::CMD_SREM);
      a_neg     = is_signed && a[31];
      b_neg     = is_signed && b[31];
      n         = a_neg ? -a : a;
      d         = b_neg ? -b : b;
      quo       = '0;
      rem       = '0;
      if (d == 0) begin
         rem = {1'b0, n};
      end else begin
         for (int i = 31; i >= 0; i--) begin
            rem = {rem[31:0], n[i]};
            if (rem >= {1'b0, d}) begin
               rem    = rem - {1'b0, d};
               quo[i] = 1'b1;
            end
         end
      end
      case (cmd)
         sudiv_pkg::CMD_UQUO: return quo;
         sudiv_pkg::CMD_UREM: return rem[31:0];
         sudiv_pkg::CMD_SQUO: return (a_neg != b_neg) ? -quo : quo;
         default:             return a_neg ? -rem[31:0] : rem[31:0];
      endcase
   endfunction

   function automatic logic [31:0] random_operand();
      case ($urandom_range(0, 6))
         0, 1: return $urandom;
         2:    return $urandom_range(0, 15);
         3:    return -$urandom_range(1, 15);
         4:    return $urandom >> $urandom_range(1, 31);
         5:    return -($urandom >> $urandom_range(1, 31));
         default: begin
            case ($urandom_range(0, 5))
               0: return 32'h0000_0000;
               1: return 32'h0000_0001;
               2: return 32'h7FFF_FFFF;
               3: return 32'h8000_0000;
               4: return 32'hFFFF_FFFF;
               default: return 32'h8000_0001;
            endcase
         end
      endcase
   endfunction

   task automatic queue_beat(sudiv_pkg::sudiv_cmd_type cmd, logic [31:0] a, logic [31:0] b,
                             bit drain, bit quiet);
      div_beat_type beat;
      beat.cmd      = cmd;
      beat.dividend = a;
      beat.divisor  = b;
      beat.gap      = quiet ? 0 : $urandom_range(0, 8);
      beat.drain    = drain;
      pending_beats.push_back(beat);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // request driver
   always @(posedge clock) begin : req_driver
      logic           next_valid;
      logic           accepted;
      div_beat_type   beat;
      div_expect_type exp_beat;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = -1;
      end else begin
         accepted   = req_valid && !req_stall;
         next_valid = req_valid && !accepted;
         if (accepted) begin
            exp_beat.cmd      = sudiv_pkg::sudiv_cmd_type'(req_command);
            exp_beat.dividend = req_dividend;
            exp_beat.divisor  = req_divisor;
            exp_beat.result   = divide_result(exp_beat.cmd, req_dividend, req_divisor);
            expected_results.push_back(exp_beat);
            beats_in <= beats_in + 1;
         end
         if (!next_valid && pending_beats.size() > 0) begin
            if (gap_left < 0)
               gap_left = pending_beats[0].gap;
            if (gap_left > 0) begin
               gap_left--;
            end else if (!pending_beats[0].drain || (!accepted && beats_in == beats_out)) begin
               beat = pending_beats.pop_front();
               req_command  <= beat.cmd;
               req_dividend <= beat.dividend;
               req_divisor  <= beat.divisor;
               next_valid   = 1'b1;
               gap_left     = -1;
            end
         end
         req_valid <= next_valid;
      end
   end

   // result monitor and checker
   always @(posedge clock) begin : rsp_monitor
      div_expect_type exp_beat;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            beats_out <= beats_out + 1;
            if (expected_results.size() == 0) begin
               $error("result: expected none, got %h", rsp_result);
               error_count++;
            end else begin
               exp_beat = expected_results.pop_front();
               if (rsp_result !== exp_beat.result) begin
                  $error("result: expected %h, got %h (%s %h / %h)", exp_beat.result,
                         rsp_result, exp_beat.cmd.name(), exp_beat.dividend, exp_beat.divisor);
                  error_count++;
               end
            end
            // every fourth stretch of 64 beats runs without back-pressure
            stall_left = ((beats_out / 64) % 4 == 1) ? 0 : $urandom_range(0, 8);
         end else if (rsp_valid && stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   initial begin : stimulus
      sudiv_pkg::sudiv_cmd_type cmd;
      logic [31:0]              a;
      logic [31:0]              b;
      bit                       quiet;

      for (int c = 0; c < 4; c++)
         for (int k = 0; k < 6; k++)
            queue_beat(sudiv_pkg::sudiv_cmd_type'(c), EDGE_DIVIDEND[k], EDGE_DIVISOR[k],
                       1'b0, 1'b0);

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         cmd   = sudiv_pkg::sudiv_cmd_type'($urandom_range(0, 3));
         a     = random_operand();
         b     = ($urandom_range(0, 3) == 0) ? (a >> $urandom_range(0, 31)) : random_operand();
         quiet = ((i / 100) % 3 == 2);
         // hold off until the core has emptied out, now and then
         queue_beat(cmd, a, b, (i % 300 == 0), quiet);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      do
         @(posedge clock);
      while (pending_beats.size() != 0 || req_valid || beats_in != beats_out);

      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_results.size() != 0) begin
         $error("result: %0d beats never returned", expected_results.size());
         error_count++;
      end

      if (error_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
